[rtl/stk_pkg.sv]
`timescale 1ns / 1ps

package stk_pkg;

  localparam int unsigned MaxDepth = 64;
  localparam int unsigned PtrW     = $clog2(MaxDepth + 1);
  localparam int unsigned LabelW   = 64;
  localparam int unsigned CountW   = 32;

  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_INSERT = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FEW    = 3'd3,
    ST_BADPOS = 3'd4
  } status_e;

  typedef struct packed {
    logic [LabelW-1:0]        label;
    logic signed [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic push_en;
    logic ins_en;
    logic rem_en;
    logic rd_en;
    ptr_t pos;
    ptr_t top;
    ptr_t rd_idx;
  } cell_ctrl_t;

endpackage

[rtl/stk_in_if.sv]
`timescale 1ns / 1ps

interface stk_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         position;
  logic [63:0]        item_label;
  logic signed [31:0] item_count;

  modport source (output valid, func, position, item_label, item_count, input ready);
  modport sink (input valid, func, position, item_label, item_count, output ready);
endinterface

[rtl/stk_out_if.sv]
`timescale 1ns / 1ps

interface stk_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [63:0]        out_label;
  logic signed [31:0] out_count;
  logic [3:0]         fill_level;

  modport source (output valid, status, out_label, out_count, fill_level, input ready);
  modport sink (input valid, status, out_label, out_count, fill_level, output ready);
endinterface

[rtl/stack_with_positional_insert_remove_top.sv]
`timescale 1ns / 1ps

// Bounded stack of DEPTH entries, each a 64-bit label and a signed 32-bit count, held in a
// row of cells that shift toward or away from the top in one step. Every input beat asks
// for push, pop, insert at a position, or remove at a position, and yields exactly one
// result beat with a status, the popped or removed entry (zero otherwise) and the fill
// level after the operation. An operation completes in the cycle it is accepted and its
// result sits in an output register in the next cycle; a new beat is taken every cycle as
// long as the result side keeps up. Throughput is one operation per cycle, set by the
// single-step shift of the cell row, as long as the result side keeps up.

module stack_with_positional_insert_remove_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stk_in_if.sink    in_i,
  stk_out_if.source out_o
);
  import stk_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] top_q, top_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  entry_t          rd_q, rd_d;
  logic [3:0]      fill_q;

  logic            accept;
  logic            push_ok, pop_ok, ins_ok, rem_ok;
  ptr_t            top_ext, pos_ext;
  logic            full, few;
  cell_ctrl_t      ctrl;
  entry_t          item;
  entry_t          cell_data [DEPTH];
  entry_t          cell_rd [DEPTH];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign top_ext = ptr_t'(top_q);
  assign pos_ext = ptr_t'(in_i.position);
  assign full    = (top_q == CntW'(DEPTH));
  assign few     = (top_ext < ptr_t'(2));

  assign item.label = in_i.item_label;
  assign item.count = in_i.item_count;

  always_comb begin
    push_ok  = 1'b0;
    pop_ok   = 1'b0;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    status_d = ST_OK;
    unique case (func_e'(in_i.func))
      FN_PUSH: begin
        if (full) status_d = ST_FULL;
        else push_ok = 1'b1;
      end
      FN_POP: begin
        if (top_q == '0) status_d = ST_EMPTY;
        else pop_ok = 1'b1;
      end
      FN_INSERT: begin
        priority if (few) status_d = ST_FEW;
        else if (full) status_d = ST_FULL;
        else if (pos_ext < ptr_t'(1) || pos_ext >= top_ext) status_d = ST_BADPOS;
        else ins_ok = 1'b1;
      end
      FN_REMOVE: begin
        priority if (few) status_d = ST_FEW;
        else if (pos_ext >= top_ext - ptr_t'(1)) status_d = ST_BADPOS;
        else rem_ok = 1'b1;
      end
      default: status_d = ST_OK;
    endcase
  end

  always_comb begin
    ctrl.push_en = accept && push_ok;
    ctrl.ins_en  = accept && ins_ok;
    ctrl.rem_en  = accept && rem_ok;
    ctrl.rd_en   = pop_ok || rem_ok;
    ctrl.pos     = pos_ext;
    ctrl.top     = top_ext;
    ctrl.rd_idx  = pop_ok ? (top_ext - ptr_t'(1)) : pos_ext;
  end

  always_comb begin
    top_d = top_q;
    if (accept) begin
      if (push_ok || ins_ok) top_d = top_q + CntW'(1);
      else if (pop_ok || rem_ok) top_d = top_q - CntW'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t below, above;
    if (g == 0) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_topc
      assign above = '0;
    end else begin : g_mid_a
      assign above = cell_data[g+1];
    end
    stk_cell #(.Idx(g)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .item_i (item),
      .below_i(below),
      .above_i(above),
      .data_o (cell_data[g]),
      .rd_o   (cell_rd[g])
    );
  end

  always_comb begin
    rd_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_d = rd_d | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      top_q <= top_d;
      if (in_i.ready) out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      fill_q   <= 4'(top_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.out_label  = rd_q.label;
  assign out_o.out_count  = rd_q.count;
  assign out_o.fill_level = fill_q;

endmodule

[rtl/stk_cell.sv]
`timescale 1ns / 1ps

module stk_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk_i,
  input  stk_pkg::cell_ctrl_t ctrl_i,
  input  stk_pkg::entry_t    item_i,
  input  stk_pkg::entry_t    below_i,
  input  stk_pkg::entry_t    above_i,
  output stk_pkg::entry_t    data_o,
  output stk_pkg::entry_t    rd_o
);
  import stk_pkg::*;

  localparam ptr_t Me = ptr_t'(Idx);

  entry_t data_q, data_d;
  ptr_t   me_next;

  assign me_next = Me + ptr_t'(1);

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.push_en && Me == ctrl_i.top) begin
      data_d = item_i;
    end else if (ctrl_i.ins_en && Me == ctrl_i.pos) begin
      data_d = item_i;
    end else if (ctrl_i.ins_en && Me > ctrl_i.pos && Me <= ctrl_i.top) begin
      data_d = below_i;
    end else if (ctrl_i.rem_en && Me >= ctrl_i.pos && me_next < ctrl_i.top) begin
      data_d = above_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctrl_i.rd_en && Me == ctrl_i.rd_idx) ? data_q : '0;

endmodule
